// File: src/otsu_pkg.sv
package otsu_pkg;

  // Histogram geometry
  localparam int NUM_BINS   = 256;
  localparam int COUNT_BITS = 24;
  localparam int SUM_W      = 32;
  localparam int IDX_W      = $clog2(NUM_BINS + 1);
  localparam int ADDR_W     = $clog2(NUM_BINS);
  localparam int THR_W      = 8;

  // Variance arithmetic widths
  localparam int MW      = 32;
  localparam int AB_W    = COUNT_BITS + SUM_W;
  localparam int DEN_W   = 2 * COUNT_BITS;
  localparam int SQ_W    = 2 * AB_W;
  localparam int PROD_W  = SQ_W + AB_W;

  // Digit-serial multiplier
  localparam int DIGIT_W   = 8;
  localparam int MUL_STEPS = (AB_W + DIGIT_W - 1) / DIGIT_W;
  localparam int STEP_W    = $clog2(MUL_STEPS + 1);

  // Tie averaging and rounding divide
  localparam int TS_W     = 2 * ADDR_W;
  localparam int NUM_W    = TS_W + 2;
  localparam int REM_W    = IDX_W + 2;
  localparam int DIVCNT_W = $clog2(NUM_W);

  // Stream widths
  localparam int IN_TDATA_W  = ((COUNT_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((THR_W + 1 + 7) / 8) * 8;

  // Job queue
  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [IDX_W-1:0]      n;
    logic [COUNT_BITS-1:0] tot;
    logic [SUM_W-1:0]      tsum;
  } job_t;

  typedef struct packed {
    logic                  en;
    logic [ADDR_W-1:0]     addr;
    logic [COUNT_BITS-1:0] cnt;
    logic [SUM_W-1:0]      sum;
  } wr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_MUL_A,
    S_MUL_B,
    S_MUL_DEN,
    S_CHECK,
    S_SQ,
    S_LHS,
    S_RHS,
    S_CMP,
    S_NEXT,
    S_DIV,
    S_DONE
  } back_state_e;

endpackage

// File: src/otsu_threshold_select.sv
// Otsu threshold over a streamed histogram. Send bin counts on the slave stream, grey level 0
// first, and mark the final bin with tlast; bins never sent count as empty, and bins beyond
// 256 are dropped. Bins load at one per cycle while tready is high. After the last bin the
// search walks every stored level through one prefix-store read port and a digit-serial
// multiplier, skipping the multiplies at a level whose split leaves a class empty; when a
// level was found, a rounding divide follows. While a search runs, the slave side holds
// tready low; the result (tdata bits 7:0 threshold, bit 8 found) waits in an output register,
// so the next histogram may load before it is taken. found is 0 and the threshold 0 when no
// level splits the pixels into two non-empty classes.
module otsu_threshold_select (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [otsu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [23:0] bin_count
  input  logic                                s_axis_tlast,  // last_bin
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [otsu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // [7:0] threshold, [8] found
);
  import otsu_pkg::*;

  wr_t              wr;
  job_t             job_in, job_out;
  logic             push, pop, fifo_empty, fifo_full, back_busy, hold;
  logic [THR_W-1:0] threshold;
  logic             found;

  // Block new bins while a histogram waits for or runs its search
  assign hold = !fifo_empty || back_busy;

  otsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .bin_count_i (s_axis_tdata[COUNT_BITS-1:0]),
    .last_bin_i  (s_axis_tlast),
    .hold_i      (hold),
    .wr_o        (wr),
    .push_o      (push),
    .job_o       (job_in)
  );

  otsu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .data_o  (job_out),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  otsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .job_i        (job_out),
    .fifo_empty_i (fifo_empty),
    .pop_o        (pop),
    .busy_o       (back_busy),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .threshold_o  (threshold),
    .found_o      (found)
  );

  assign m_axis_tdata = OUT_TDATA_W'({found, threshold});

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_full)
    else $error("job pushed into a full queue");

endmodule

// File: src/otsu_front.sv
module otsu_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [otsu_pkg::COUNT_BITS-1:0] bin_count_i,
  input  logic                           last_bin_i,
  input  logic                           hold_i,
  output otsu_pkg::wr_t                  wr_o,
  output logic                           push_o,
  output otsu_pkg::job_t                 job_o
);
  import otsu_pkg::*;

  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [COUNT_BITS-1:0] pc_q, pc_d, cnt_new;
  logic [SUM_W-1:0]      ps_q, ps_d, sum_new;
  logic                  acc, room;

  assign ready_o = !hold_i;
  assign acc     = valid_i && ready_o;
  assign room    = idx_q < IDX_W'(NUM_BINS);

  // Running prefix count and level-weighted sum
  assign cnt_new = pc_q + bin_count_i;
  assign sum_new = ps_q + SUM_W'(idx_q) * SUM_W'(bin_count_i);

  // Store the prefix entry of this level
  always_comb begin
    wr_o.en   = acc && room;
    wr_o.addr = idx_q[ADDR_W-1:0];
    wr_o.cnt  = cnt_new;
    wr_o.sum  = sum_new;
  end

  // Hand a finished histogram to the search
  always_comb begin
    push_o     = acc && last_bin_i;
    job_o.n    = room ? idx_q + 1'b1 : idx_q;
    job_o.tot  = room ? cnt_new : pc_q;
    job_o.tsum = room ? sum_new : ps_q;
  end

  always_comb begin
    idx_d = idx_q;
    pc_d  = pc_q;
    ps_d  = ps_q;
    if (acc) begin
      if (last_bin_i) begin
        idx_d = '0;
        pc_d  = '0;
        ps_d  = '0;
      end else if (room) begin
        idx_d = idx_q + 1'b1;
        pc_d  = cnt_new;
        ps_d  = sum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      pc_q  <= '0;
      ps_q  <= '0;
    end else begin
      idx_q <= idx_d;
      pc_q  <= pc_d;
      ps_q  <= ps_d;
    end
  end

endmodule

// File: src/otsu_fifo.sv
module otsu_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  otsu_pkg::job_t data_i,
  input  logic           pop_i,
  output otsu_pkg::job_t data_o,
  output logic           empty_o,
  output logic           full_o
);
  import otsu_pkg::*;

  job_t              mem_q [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_q, rd_q;
  logic [FPTR_W:0]   cnt_q;

  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == (FPTR_W + 1)'(FIFO_DEPTH);
  assign data_o  = mem_q[rd_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (FPTR_W + 1)'(push_i && !full_o) - (FPTR_W + 1)'(pop_i && !empty_o);
    end
  end

endmodule

// File: src/otsu_smul.sv
module otsu_smul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [otsu_pkg::SQ_W-1:0]   a_i,
  input  logic [otsu_pkg::AB_W-1:0]   b_i,
  output logic                        done_o,
  output logic [otsu_pkg::PROD_W-1:0] p_o
);
  import otsu_pkg::*;

  logic [PROD_W-1:0] a_q, acc_q;
  logic [AB_W-1:0]   b_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [PROD_W-1:0] part;

  // One digit of the multiplier per cycle
  assign part   = PROD_W'(a_q * b_q[DIGIT_W-1:0]);
  assign done_o = done_q;
  assign p_o    = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        a_q    <= PROD_W'(a_i);
        b_q    <= b_i;
        acc_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q <= acc_q + part;
        a_q   <= a_q << DIGIT_W;
        b_q   <= b_q >> DIGIT_W;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == STEP_W'(MUL_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/otsu_back.sv
module otsu_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  otsu_pkg::wr_t              wr_i,
  input  otsu_pkg::job_t             job_i,
  input  logic                       fifo_empty_i,
  output logic                       pop_o,
  output logic                       busy_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [otsu_pkg::THR_W-1:0] threshold_o,
  output logic                       found_o
);
  import otsu_pkg::*;

  // Prefix stores
  logic [COUNT_BITS-1:0] cnt_mem [NUM_BINS];
  logic [SUM_W-1:0]      sum_mem [NUM_BINS];

  back_state_e state_q, state_d;

  logic [IDX_W-1:0]      n_q;
  logic [COUNT_BITS-1:0] tot_q, w_q;
  logic [SUM_W-1:0]      tsum_q, s_q;
  logic [ADDR_W-1:0]     k_q;
  logic [AB_W-1:0]       a_q, b_q, d;
  logic [DEN_W-1:0]      den_q, best_den_q;
  logic [SQ_W-1:0]       dsq_q, best_sq_q;
  logic [PROD_W-1:0]     lhs_q;
  logic                  found_q;
  logic [TS_W-1:0]       ts_q;
  logic [IDX_W-1:0]      tc_q;
  logic [NUM_W-1:0]      num_q, quo_q;
  logic [REM_W-1:0]      rem_q, rem_sh, dvs;
  logic [DIVCNT_W-1:0]   div_cnt_q;
  logic                  ge;
  logic                  out_valid_q, fnd_q;
  logic [THR_W-1:0]      thr_q;

  logic                  rd_en, is_last, out_load;
  logic [MW-1:0]         mul_a, mul_b;
  logic [2*MW-1:0]       mul_p;
  logic                  sm_start, sm_done;
  logic [SQ_W-1:0]       sm_a;
  logic [AB_W-1:0]       sm_b;
  logic [PROD_W-1:0]     sm_p;

  otsu_smul u_smul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sm_start),
    .a_i     (sm_a),
    .b_i     (sm_b),
    .done_o  (sm_done),
    .p_o     (sm_p)
  );

  // Write from the front, registered read for the search
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      cnt_mem[wr_i.addr] <= wr_i.cnt;
      sum_mem[wr_i.addr] <= wr_i.sum;
    end
    if (rd_en) begin
      w_q <= cnt_mem[k_q];
      s_q <= sum_mem[k_q];
    end
  end

  assign mul_p    = mul_a * mul_b;
  assign d        = (a_q > b_q) ? a_q - b_q : b_q - a_q;
  assign is_last  = (IDX_W'(k_q) + 1'b1) == n_q;
  assign out_load = !out_valid_q || out_ready_i;
  assign dvs      = REM_W'({tc_q, 1'b0});
  assign rem_sh   = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
  assign ge       = rem_sh >= dvs;

  assign busy_o      = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign threshold_o = thr_q;
  assign found_o     = fnd_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (!fifo_empty_i) state_d = S_READ;
      S_READ:    state_d = S_MUL_A;
      S_MUL_A:   state_d = S_MUL_B;
      S_MUL_B:   state_d = S_MUL_DEN;
      S_MUL_DEN: state_d = S_CHECK;
      S_CHECK:   state_d = (den_q != '0) ? S_SQ : S_NEXT;
      S_SQ:      if (sm_done) state_d = found_q ? S_LHS : S_NEXT;
      S_LHS:     if (sm_done) state_d = S_RHS;
      S_RHS:     if (sm_done) state_d = S_CMP;
      S_CMP:     state_d = S_NEXT;
      S_NEXT: begin
        if (is_last) state_d = found_q ? S_DIV : S_DONE;
        else state_d = S_READ;
      end
      S_DIV:     if (div_cnt_q == DIVCNT_W'(NUM_W - 1)) state_d = S_DONE;
      S_DONE:    if (out_load) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Control outputs and operand selection
  always_comb begin
    pop_o    = 1'b0;
    rd_en    = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    sm_start = 1'b0;
    sm_a     = '0;
    sm_b     = '0;
    unique case (state_q)
      S_IDLE: pop_o = !fifo_empty_i;
      S_READ: rd_en = 1'b1;
      S_MUL_A: begin
        mul_a = MW'(tsum_q);
        mul_b = MW'(w_q);
      end
      S_MUL_B: begin
        mul_a = MW'(tot_q);
        mul_b = MW'(s_q);
      end
      S_MUL_DEN: begin
        mul_a = MW'(w_q);
        mul_b = MW'(COUNT_BITS'(tot_q - w_q));
      end
      S_CHECK: begin
        sm_start = den_q != '0;
        sm_a     = SQ_W'(d);
        sm_b     = d;
      end
      S_SQ: begin
        sm_start = sm_done && found_q;
        sm_a     = sm_p[SQ_W-1:0];
        sm_b     = AB_W'(best_den_q);
      end
      S_LHS: begin
        sm_start = sm_done;
        sm_a     = best_sq_q;
        sm_b     = AB_W'(den_q);
      end
      default: ;
    endcase
  end

  // Search datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      tot_q       <= '0;
      tsum_q      <= '0;
      k_q         <= '0;
      a_q         <= '0;
      b_q         <= '0;
      den_q       <= '0;
      best_den_q  <= '0;
      dsq_q       <= '0;
      best_sq_q   <= '0;
      lhs_q       <= '0;
      found_q     <= 1'b0;
      ts_q        <= '0;
      tc_q        <= '0;
      num_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      fnd_q       <= 1'b0;
      thr_q       <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          if (!fifo_empty_i) begin
            n_q     <= job_i.n;
            tot_q   <= job_i.tot;
            tsum_q  <= job_i.tsum;
            k_q     <= '0;
            found_q <= 1'b0;
            ts_q    <= '0;
            tc_q    <= '0;
          end
        end
        S_MUL_A:   a_q   <= mul_p[AB_W-1:0];
        S_MUL_B:   b_q   <= mul_p[AB_W-1:0];
        S_MUL_DEN: den_q <= mul_p[DEN_W-1:0];
        S_SQ: begin
          if (sm_done) begin
            dsq_q <= sm_p[SQ_W-1:0];
            // first level with two non-empty classes wins outright
            if (!found_q) begin
              found_q    <= 1'b1;
              best_sq_q  <= sm_p[SQ_W-1:0];
              best_den_q <= den_q;
              ts_q       <= TS_W'(k_q);
              tc_q       <= IDX_W'(1);
            end
          end
        end
        S_LHS: if (sm_done) lhs_q <= sm_p;
        S_CMP: begin
          if (lhs_q > sm_p) begin
            best_sq_q  <= dsq_q;
            best_den_q <= den_q;
            ts_q       <= TS_W'(k_q);
            tc_q       <= IDX_W'(1);
          end else if (lhs_q == sm_p) begin
            ts_q <= ts_q + TS_W'(k_q);
            tc_q <= tc_q + 1'b1;
          end
        end
        S_NEXT: begin
          k_q       <= k_q + 1'b1;
          num_q     <= NUM_W'({ts_q, 1'b0}) + NUM_W'(tc_q);
          quo_q     <= '0;
          rem_q     <= '0;
          div_cnt_q <= '0;
        end
        S_DIV: begin
          rem_q     <= ge ? rem_sh - dvs : rem_sh;
          quo_q     <= {quo_q[NUM_W-2:0], ge};
          num_q     <= num_q << 1;
          div_cnt_q <= div_cnt_q + 1'b1;
        end
        default: ;
      endcase

      // Output register
      if (state_q == S_DONE && out_load) begin
        out_valid_q <= 1'b1;
        fnd_q       <= found_q;
        thr_q       <= found_q ? THR_W'(quo_q) : '0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_found_has_tie: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> tc_q != '0)
    else $error("best level recorded with empty tie count");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result presented outside the finish state");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> IDX_W'(k_q) < n_q)
    else $error("search read beyond stored bins");

endmodule
